/* hw/rtl/gating_block_energy_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the gating block energy unit
// Shared property templates, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GATING_BLOCK_ENERGY_UNIT_ASSERT_SVH
`define GATING_BLOCK_ENERGY_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gbe_pkg.sv */
// ----------------------------------------------------------------------------
// Gating block energy package
// Widths, reset values, register indexes, controller states and the
// channel weight table shared by the gating block energy unit.
// ----------------------------------------------------------------------------
package gbe_pkg;

  // Fixed field widths.
  localparam int GBE_MAG_W      = 24;   // aligned sample magnitude, 23 fraction bits
  localparam int GBE_SQ_W       = 48;
  localparam int GBE_WT_W       = 16;   // Q2.14 weight
  localparam int GBE_WT_FRAC    = 14;
  localparam int GBE_ACC_W      = 64;
  localparam int GBE_MEAN_W     = 50;
  localparam int GBE_SPB_W      = 16;
  localparam int GBE_CW_W       = 16;
  localparam int GBE_CC_W       = 4;
  localparam int GBE_CH_W       = 3;
  localparam int GBE_CFG_IDX_W  = 3;
  localparam int GBE_CFG_DATA_W = 50;
  localparam int GBE_OUT_TDATA_W = ((GBE_MEAN_W + 7) / 8) * 8;
  localparam int GBE_MAX_CHANNELS = 8;

  // Parameter defaults.
  localparam int GBE_SAMPLE_BITS       = 24;
  localparam int GBE_HISTORY_SUBBLOCKS = 30;
  localparam int GBE_BLOCK_SUBBLOCKS   = 4;

  // Register reset values.
  localparam logic [GBE_SPB_W-1:0]  GBE_RST_SPB  = 16'd4800;
  localparam logic [GBE_CW_W-1:0]   GBE_RST_CW   = 16'd5;
  localparam logic [GBE_CC_W-1:0]   GBE_RST_CC   = 4'd2;
  localparam logic [GBE_MEAN_W-1:0] GBE_RST_GATE = 50'd8250000;
  localparam logic                  GBE_RST_EN_M = 1'b1;
  localparam logic                  GBE_RST_EN_S = 1'b0;

  localparam logic [GBE_MEAN_W-1:0] GBE_MEAN_MAX = '1;

  typedef enum logic [GBE_CFG_IDX_W-1:0] {
    CFG_SPB      = 3'd0,
    CFG_WEIGHTS  = 3'd1,
    CFG_CHANNELS = 3'd2,
    CFG_GATE     = 3'd3,
    CFG_EN_MOM   = 3'd4,
    CFG_EN_SHORT = 3'd5
  } gbe_cfg_idx_t;

  typedef enum logic {
    KIND_MOMENTARY = 1'b0,
    KIND_SHORTTERM = 1'b1
  } gbe_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_WEIGHT,
    ST_ACCUM,
    ST_FRAME,
    ST_SELECT,
    ST_LOAD,
    ST_SUM,
    ST_DSTART,
    ST_DWAIT,
    ST_ROUND,
    ST_GATE,
    ST_EMIT
  } gbe_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic      capture;
    logic      square;
    logic      weight;
    logic      accum;
    logic      frame;
    logic      load;
    logic      sum_run;
    logic      div_start;
    logic      round;
    logic      out_load;
    gbe_kind_t kind;
    gbe_kind_t out_kind;
    logic      out_last;
  } gbe_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic fend;
    logic complete;
    logic need_m;
    logic need_s;
    logic sum_done;
    logic div_done;
    logic pass;
    logic out_free;
  } gbe_sts_t;

  // Q2.14 weight for a two-bit channel weight code.
  function automatic logic [GBE_WT_W-1:0] gbe_weight(input logic [1:0] code);
    logic [GBE_WT_W-1:0] w;
    unique case (code)
      2'd0:    w = 16'd0;
      2'd1:    w = 16'd16384;
      2'd2:    w = 16'd23101;
      default: w = 16'd32768;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/gating_block_energy_unit.sv */
// ----------------------------------------------------------------------------
// Gating block energy unit
// Weighted mean square energy of 400 ms and 3 s loudness blocks, gated.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word contents
//  in_      slave      sample in tdata, channel in tuser, frame end in tlast
//  out_     master     mean energy in tdata, block kind in tuser, tlast on the
//                      final result of an input word
//  cfg_     slave      register index and write data, always ready
//
// An input word that does not end a frame goes through capture, square,
// weight multiply and accumulate. A frame end adds a frame step; closing a
// subblock then adds, per block mean computed, a summation of N subblocks
// (one history read per cycle), the bit-serial divider, rounding and the
// gate compare. Emitting a result waits while the output register is still
// held by the sink. Reset is synchronous and active low; the history
// memory is not cleared, since a slot is only read once it has been
// written. A result waiting in the output register does not stop the next
// input word from being taken, unless a second result still waits for it.
//
module gating_block_energy_unit
  import gbe_pkg::*;
#(
  parameter int SAMPLE_BITS       = GBE_SAMPLE_BITS,
  parameter int HISTORY_SUBBLOCKS = GBE_HISTORY_SUBBLOCKS,
  parameter int BLOCK_SUBBLOCKS   = GBE_BLOCK_SUBBLOCKS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input words.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,   // sample, then zero pad
  input  logic [GBE_CH_W-1:0]              in_tuser,   // channel
  input  logic                             in_tlast,   // frame end
  // Result words.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [GBE_OUT_TDATA_W-1:0]       out_tdata,  // mean energy, then zero pad
  output logic [0:0]                       out_tuser,  // block kind
  output logic                             out_tlast,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [GBE_CFG_IDX_W-1:0]         cfg_index,
  input  logic [GBE_CFG_DATA_W-1:0]        cfg_data
);

  gbe_cmd_t cmd;
  gbe_sts_t sts;

  logic [GBE_MEAN_W-1:0] out_mean;
  logic                  out_kind;

  // The controller sequences each word; the datapath holds all arithmetic
  // and data registers, including the output register that decouples the sink.
  gbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbe_dp #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .HISTORY_SUBBLOCKS (HISTORY_SUBBLOCKS),
    .BLOCK_SUBBLOCKS   (BLOCK_SUBBLOCKS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_sample    (in_tdata[SAMPLE_BITS-1:0]),
    .in_channel   (in_tuser),
    .in_frame_end (in_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .out_mean     (out_mean),
    .out_kind     (out_kind),
    .out_last     (out_tlast),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Pad the mean energy up to whole bytes.
  assign out_tdata = {{(GBE_OUT_TDATA_W - GBE_MEAN_W){1'b0}}, out_mean};
  assign out_tuser = out_kind;

endmodule

/* hw/rtl/gbe_div.sv */
// ----------------------------------------------------------------------------
// Gating block energy divider
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module gbe_div
  import gbe_pkg::*;
#(
  parameter int NUM_W = GBE_ACC_W,
  parameter int DEN_W = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

/* hw/rtl/gbe_dp.sv */
// ----------------------------------------------------------------------------
// Gating block energy datapath
// Configuration registers, weighted square accumulation, subblock history,
// block summation and division, rounding, gate compare and output register.
// ----------------------------------------------------------------------------
`include "gating_block_energy_unit_assert.svh"

module gbe_dp
  import gbe_pkg::*;
#(
  parameter int SAMPLE_BITS       = GBE_SAMPLE_BITS,
  parameter int HISTORY_SUBBLOCKS = GBE_HISTORY_SUBBLOCKS,
  parameter int BLOCK_SUBBLOCKS   = GBE_BLOCK_SUBBLOCKS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [GBE_CH_W-1:0]       in_channel,
  input  logic                      in_frame_end,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [GBE_CFG_IDX_W-1:0]  cfg_index,
  input  logic [GBE_CFG_DATA_W-1:0] cfg_data,
  input  logic                      out_tready,
  output logic                      out_valid,
  output logic [GBE_MEAN_W-1:0]     out_mean,
  output logic                      out_kind,
  output logic                      out_last,
  input  gbe_cmd_t                  cmd,
  output gbe_sts_t                  sts
);

  localparam int PTR_W   = $clog2(HISTORY_SUBBLOCKS);
  localparam int CNT_MAX = (HISTORY_SUBBLOCKS > BLOCK_SUBBLOCKS) ?
                           HISTORY_SUBBLOCKS : BLOCK_SUBBLOCKS;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int DEN_W   = CNT_W + GBE_SPB_W;

  // Configuration.
  logic [GBE_SPB_W-1:0]  spb_r;
  logic [GBE_CW_W-1:0]   cw_r;
  logic [GBE_CC_W-1:0]   cc_r;
  logic [GBE_MEAN_W-1:0] gate_r;
  logic                  en_m_r;
  logic                  en_s_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r  <= GBE_RST_SPB;
      cw_r   <= GBE_RST_CW;
      cc_r   <= GBE_RST_CC;
      gate_r <= GBE_RST_GATE;
      en_m_r <= GBE_RST_EN_M;
      en_s_r <= GBE_RST_EN_S;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPB:      spb_r  <= cfg_data[GBE_SPB_W-1:0];
        CFG_WEIGHTS:  cw_r   <= cfg_data[GBE_CW_W-1:0];
        CFG_CHANNELS: cc_r   <= cfg_data[GBE_CC_W-1:0];
        CFG_GATE:     gate_r <= cfg_data[GBE_MEAN_W-1:0];
        CFG_EN_MOM:   en_m_r <= cfg_data[0];
        CFG_EN_SHORT: en_s_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [GBE_SPB_W-1:0] spb_eff;
  assign spb_eff = (spb_r == '0) ? GBE_SPB_W'(1) : spb_r;

  // Sample capture: magnitude aligned to 23 fraction bits, weight looked up.
  logic [SAMPLE_BITS-1:0] raw_u;
  logic [SAMPLE_BITS-1:0] mag_full;
  logic [GBE_MAG_W-1:0]   mag_al;
  logic                   ch_in_frame;

  assign raw_u    = in_sample;
  assign mag_full = raw_u[SAMPLE_BITS-1] ? (~raw_u + 1'b1) : raw_u;

  generate
    if (SAMPLE_BITS >= GBE_MAG_W) begin : g_down
      assign mag_al = GBE_MAG_W'(mag_full >> (SAMPLE_BITS - GBE_MAG_W));
    end else begin : g_up
      assign mag_al = {mag_full, {(GBE_MAG_W - SAMPLE_BITS){1'b0}}};
    end
  endgenerate

  assign ch_in_frame = ({1'b0, in_channel} < cc_r) &&
                       (int'(in_channel) < GBE_MAX_CHANNELS);

  logic [GBE_MAG_W-1:0] mag_r;
  logic [GBE_WT_W-1:0]  wt_r;
  logic                 fend_r;
  logic [GBE_SQ_W-1:0]  sq_r;
  logic [GBE_ACC_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag_r  <= mag_al;
      wt_r   <= ch_in_frame ? gbe_weight(cw_r[{in_channel, 1'b0} +: 2]) : '0;
      fend_r <= in_frame_end;
    end
    if (cmd.square) begin
      sq_r <= mag_r * mag_r;
    end
    if (cmd.weight) begin
      prod_r <= GBE_ACC_W'(sq_r * wt_r);
    end
  end

  // Accumulate with round half up folded in as a carry.
  logic [GBE_ACC_W:0]   acc_sum;
  logic [GBE_ACC_W-1:0] acc_r;
  logic [GBE_SPB_W-1:0] fc_r;
  logic [GBE_SPB_W-1:0] fc_inc;
  logic                 complete;
  logic [PTR_W-1:0]     wp_r;
  logic [CNT_W-1:0]     fill_r;

  assign acc_sum = {1'b0, acc_r}
                 + (GBE_ACC_W+1)'(prod_r[GBE_ACC_W-1:GBE_WT_FRAC])
                 + (GBE_ACC_W+1)'(prod_r[GBE_WT_FRAC-1]);
  assign fc_inc   = fc_r + 1'b1;
  assign complete = fc_inc >= spb_eff;

  // Summation over the history ring.
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     rd_left_r;
  logic                 rd_vld_r;
  logic [GBE_ACC_W-1:0] rdata_r;
  logic [GBE_ACC_W-1:0] sum_r;
  logic [GBE_ACC_W:0]   sum_add;
  logic [CNT_W-1:0]     cnt_sel;
  logic [PTR_W-1:0]     wp_prev;
  logic [PTR_W-1:0]     rd_prev;
  logic [DEN_W-1:0]     d_r;

  assign cnt_sel = (cmd.kind == KIND_SHORTTERM) ? CNT_W'(HISTORY_SUBBLOCKS)
                                                : CNT_W'(BLOCK_SUBBLOCKS);
  assign wp_prev = (wp_r == '0) ? PTR_W'(HISTORY_SUBBLOCKS - 1) : wp_r - 1'b1;
  assign rd_prev = (rd_ptr_r == '0) ? PTR_W'(HISTORY_SUBBLOCKS - 1) : rd_ptr_r - 1'b1;
  assign sum_add = {1'b0, sum_r} + {1'b0, rdata_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      fc_r      <= '0;
      wp_r      <= '0;
      fill_r    <= '0;
      rd_left_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cmd.accum) begin
        acc_r <= acc_sum[GBE_ACC_W] ? '1 : acc_sum[GBE_ACC_W-1:0];
      end
      if (cmd.frame) begin
        if (complete) begin
          fc_r  <= '0;
          acc_r <= '0;
          wp_r  <= (wp_r == PTR_W'(HISTORY_SUBBLOCKS - 1)) ? '0 : wp_r + 1'b1;
          if (fill_r < CNT_W'(HISTORY_SUBBLOCKS)) begin
            fill_r <= fill_r + 1'b1;
          end
        end else begin
          fc_r <= fc_inc;
        end
      end
      if (cmd.load) begin
        rd_left_r <= cnt_sel;
        rd_vld_r  <= 1'b0;
      end else if (cmd.sum_run) begin
        rd_vld_r <= rd_left_r != '0;
        if (rd_left_r != '0) begin
          rd_left_r <= rd_left_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_ptr_r <= wp_prev;
      sum_r    <= '0;
      d_r      <= cnt_sel * spb_eff;
    end else if (cmd.sum_run) begin
      if (rd_left_r != '0) begin
        rd_ptr_r <= rd_prev;
      end
      if (rd_vld_r) begin
        sum_r <= sum_add[GBE_ACC_W] ? '1 : sum_add[GBE_ACC_W-1:0];
      end
    end
  end

  // History memory: one write port, one registered read port.
  logic [GBE_ACC_W-1:0] hist_mem [HISTORY_SUBBLOCKS];

  always_ff @(posedge clk) begin
    if (cmd.frame && complete) begin
      hist_mem[wp_r] <= acc_r;
    end
    if (cmd.sum_run && rd_left_r != '0) begin
      rdata_r <= hist_mem[rd_ptr_r];
    end
  end

  // Division, rounding and saturation of the block mean.
  logic [GBE_ACC_W-1:0]  div_quo;
  logic [DEN_W-1:0]      div_rem;
  logic                  div_done;
  logic                  round_up;
  logic [GBE_MEAN_W-1:0] mean_rnd;
  logic [GBE_MEAN_W-1:0] mean_r [2];

  gbe_div #(
    .NUM_W (GBE_ACC_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (sum_r),
    .den   (d_r),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  assign round_up = {div_rem, 1'b0} >= {1'b0, d_r};

  always_comb begin
    priority if (div_quo[GBE_ACC_W-1:GBE_MEAN_W] != '0) begin
      mean_rnd = GBE_MEAN_MAX;
    end else if (div_quo[GBE_MEAN_W-1:0] == GBE_MEAN_MAX && round_up) begin
      mean_rnd = GBE_MEAN_MAX;
    end else begin
      mean_rnd = div_quo[GBE_MEAN_W-1:0] + GBE_MEAN_W'(round_up);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      mean_r[cmd.kind] <= mean_rnd;
    end
  end

  // Output register.
  logic                  out_valid_r;
  logic [GBE_MEAN_W-1:0] out_mean_r;
  logic                  out_kind_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mean_r <= mean_r[cmd.out_kind];
      out_kind_r <= cmd.out_kind;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

  // Status.
  assign sts.fend     = fend_r;
  assign sts.complete = complete;
  assign sts.need_m   = en_m_r && (fill_r >= CNT_W'(BLOCK_SUBBLOCKS));
  assign sts.need_s   = en_s_r && (fill_r >= CNT_W'(HISTORY_SUBBLOCKS));
  assign sts.sum_done = (rd_left_r == '0) && !rd_vld_r;
  assign sts.div_done = div_done;
  assign sts.pass     = mean_r[cmd.kind] >= gate_r;
  assign sts.out_free = !out_valid_r || out_tready;

  `GBE_ASSERT_IMPL(a_out_no_overwrite, cmd.out_load, !out_valid_r || out_tready, "result overwritten")
  `GBE_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= CNT_W'(HISTORY_SUBBLOCKS), "history fill overflow")
  `GBE_ASSERT_IMPL(a_sum_written_only, cmd.load, fill_r >= cnt_sel, "block reads unwritten history")
  `GBE_ASSERT_NEXT(a_div_rem_bound, div_done && cmd.round, round_up == ({div_rem, 1'b0} >= {1'b0, d_r}) && $stable(d_r), "divisor changed during rounding")

endmodule

/* hw/rtl/gbe_ctrl.sv */
// ----------------------------------------------------------------------------
// Gating block energy controller
// Sequences sample accumulation, subblock close, the two block means and
// the delivery of results.
// ----------------------------------------------------------------------------
module gbe_ctrl
  import gbe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  gbe_sts_t sts,
  output gbe_cmd_t cmd
);

  gbe_state_t state_r, state_nxt;
  gbe_kind_t  kind_r, kind_nxt;
  logic [1:0] pass_r, pass_nxt;   // gate passed, indexed by block kind

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_MOMENTARY;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    pass_nxt  = pass_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_WEIGHT;
      ST_WEIGHT: state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = sts.fend ? ST_FRAME : ST_IDLE;
      ST_FRAME:  state_nxt = sts.complete ? ST_SELECT : ST_IDLE;
      ST_SELECT: begin
        pass_nxt = '0;
        priority if (sts.need_m) begin
          kind_nxt  = KIND_MOMENTARY;
          state_nxt = ST_LOAD;
        end else if (sts.need_s) begin
          kind_nxt  = KIND_SHORTTERM;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD:   state_nxt = ST_SUM;
      ST_SUM:    if (sts.sum_done) state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT:  if (sts.div_done) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_GATE;
      ST_GATE: begin
        pass_nxt[kind_r] = sts.pass;
        if (kind_r == KIND_MOMENTARY && sts.need_s) begin
          kind_nxt  = KIND_SHORTTERM;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        priority if (pass_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          if (pass_r[KIND_MOMENTARY]) begin
            pass_nxt[KIND_MOMENTARY] = 1'b0;
            if (!pass_r[KIND_SHORTTERM]) state_nxt = ST_IDLE;
          end else begin
            pass_nxt[KIND_SHORTTERM] = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.kind  = kind_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_SQUARE: cmd.square    = 1'b1;
      ST_WEIGHT: cmd.weight    = 1'b1;
      ST_ACCUM:  cmd.accum     = 1'b1;
      ST_FRAME:  cmd.frame     = 1'b1;
      ST_LOAD:   cmd.load      = 1'b1;
      ST_SUM:    cmd.sum_run   = 1'b1;
      ST_DSTART: cmd.div_start = 1'b1;
      ST_ROUND:  cmd.round     = 1'b1;
      ST_EMIT: begin
        cmd.out_load = (pass_r != '0) && sts.out_free;
        cmd.out_kind = pass_r[KIND_MOMENTARY] ? KIND_MOMENTARY : KIND_SHORTTERM;
        cmd.out_last = pass_r[KIND_MOMENTARY] ? !pass_r[KIND_SHORTTERM] : 1'b1;
      end
      default: ;
    endcase
  end

endmodule
